### rtl/core/button_sequence_detector_defines.svh
// Assertion macros shared by the button sequence detector RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef BUTTON_SEQUENCE_DETECTOR_DEFINES_SVH
`define BUTTON_SEQUENCE_DETECTOR_DEFINES_SVH

// Clocked property with reset masking.
`define BSD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Plain expression that must hold at every clock edge outside reset.
`define BSD_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  `BSD_ASSERT(label, clk, rst, (expr), msg)

`endif

### rtl/core/bsd_pkg.sv
// Package of the button sequence detector: sizes, codes and bundled types.
// Depends on nothing; used by the channel interfaces and all modules.
`default_nettype none

package bsd_pkg;

  // Window geometry and field widths.
  localparam int WINDOW_LEN   = 8;
  localparam int BUTTON_BITS  = 4;
  localparam int WIN_BITS     = WINDOW_LEN * BUTTON_BITS;
  localparam int PATTERN_BITS = 32;
  localparam int PAT_EXT_BITS = (WIN_BITS > PATTERN_BITS) ? WIN_BITS : PATTERN_BITS;
  localparam int COUNT_BITS   = $clog2(WINDOW_LEN + 1);
  localparam int NUM_PATTERNS = 2;
  localparam int GROUP_BITS   = 4;
  localparam int REQ_BITS     = 2;
  localparam int CODE_BITS    = 4;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  // Request codes of an input item.
  typedef enum logic [REQ_BITS-1:0] {
    REQ_BUTTON  = 2'd0,
    REQ_CLEAR   = 2'd1,
    REQ_RESTART = 2'd2
  } req_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BUTTONS_ENABLED = 3'd0,
    CFG_PATTERN_FIRST   = 3'd1,
    CFG_PATTERN_SECOND  = 3'd2,
    CFG_EGG_ENABLE      = 3'd3,
    CFG_GROUP_FIRST     = 3'd4,
    CFG_GROUP_SECOND    = 3'd5,
    CFG_PERSISTENT_MASK = 3'd6
  } cfg_idx_t;

  typedef logic [WINDOW_LEN-1:0][BUTTON_BITS-1:0] window_t;

  typedef struct packed {
    logic                    buttons_enabled;
    logic [PATTERN_BITS-1:0] pattern_first;
    logic [PATTERN_BITS-1:0] pattern_second;
    logic [NUM_PATTERNS-1:0] egg_enable;
    logic [GROUP_BITS-1:0]   group_first;
    logic [GROUP_BITS-1:0]   group_second;
    logic [NUM_PATTERNS-1:0] persistent_mask;
  } cfg_t;

  typedef struct packed {
    window_t                 window;
    logic [COUNT_BITS-1:0]   count;
    logic [NUM_PATTERNS-1:0] unlocked;
    logic                    msg_pending;
    logic                    msg_index;
  } state_t;

  typedef struct packed {
    logic [REQ_BITS-1:0]  req_type;
    logic [CODE_BITS-1:0] button_code;
    logic                 pressed;
  } item_t;

  typedef struct packed {
    logic                    matched;
    logic                    matched_egg;
    logic                    newly_unlocked;
    logic [NUM_PATTERNS-1:0] unlocked_mask;
    logic                    have_message;
    logic                    message_egg;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/bsd_channels.sv
// Valid/ready channel interfaces for button events and detector results.
// Depends on bsd_pkg for the field widths.
`default_nettype none

interface bsd_event_if;
  logic                          valid;
  logic                          ready;
  logic [bsd_pkg::REQ_BITS-1:0]  req_type;
  logic [bsd_pkg::CODE_BITS-1:0] button_code;
  logic                          pressed;

  modport source (output valid, req_type, button_code, pressed, input ready);
  modport sink   (input valid, req_type, button_code, pressed, output ready);
endinterface

interface bsd_result_if;
  logic                             valid;
  logic                             ready;
  logic                             matched;
  logic                             matched_egg;
  logic                             newly_unlocked;
  logic [bsd_pkg::NUM_PATTERNS-1:0] unlocked_mask;
  logic                             have_message;
  logic                             message_egg;

  modport source (output valid, matched, matched_egg, newly_unlocked, unlocked_mask,
                  have_message, message_egg, input ready);
  modport sink   (input valid, matched, matched_egg, newly_unlocked, unlocked_mask,
                  have_message, message_egg, output ready);
endinterface

`default_nettype wire

### rtl/core/bsd_step.sv
// Next-state and result logic of the button sequence detector for one item.
// Depends on bsd_pkg; instantiated by button_sequence_detector.
`default_nettype none

module bsd_step (
  input  bsd_pkg::cfg_t    cfg,
  input  bsd_pkg::state_t  state,
  input  bsd_pkg::item_t   item,
  output bsd_pkg::state_t  state_next,
  output bsd_pkg::result_t result
);

  logic                                push;
  logic                                full;
  logic [bsd_pkg::BUTTON_BITS-1:0]     code;
  bsd_pkg::window_t                    shifted;
  logic [bsd_pkg::PAT_EXT_BITS-1:0]    pat0_ext;
  logic [bsd_pkg::PAT_EXT_BITS-1:0]    pat1_ext;
  logic                                hit0;
  logic                                hit1;
  logic                                matched;
  logic                                egg;
  logic [bsd_pkg::GROUP_BITS-1:0]      win_group;
  logic [bsd_pkg::NUM_PATTERNS-1:0]    group_clr;
  logic [bsd_pkg::NUM_PATTERNS-1:0]    flags_kept;
  logic [bsd_pkg::NUM_PATTERNS-1:0]    egg_bit;

  // A full press enters the window as the newest entry; the oldest sits at index 0.
  assign code    = bsd_pkg::BUTTON_BITS'(item.button_code);
  assign push    = (item.req_type == bsd_pkg::REQ_BUTTON) && cfg.buttons_enabled &&
                   item.pressed &&
                   (state.count < bsd_pkg::COUNT_BITS'(bsd_pkg::WINDOW_LEN));
  assign full    = (state.count == bsd_pkg::COUNT_BITS'(bsd_pkg::WINDOW_LEN - 1));
  assign shifted = {code, state.window[bsd_pkg::WINDOW_LEN-1:1]};

  // Pattern bits beyond the register read as zero.
  assign pat0_ext = bsd_pkg::PAT_EXT_BITS'(cfg.pattern_first);
  assign pat1_ext = bsd_pkg::PAT_EXT_BITS'(cfg.pattern_second);
  assign hit0 = cfg.egg_enable[0] && (shifted == pat0_ext[bsd_pkg::WIN_BITS-1:0]);
  assign hit1 = cfg.egg_enable[1] && (shifted == pat1_ext[bsd_pkg::WIN_BITS-1:0]);

  // The first pattern wins when both match.
  assign matched = push && full && (hit0 || hit1);
  assign egg     = matched && !hit0;

  // Every pattern in the winner's nonzero group loses its unlock first.
  assign win_group  = egg ? cfg.group_second : cfg.group_first;
  assign group_clr  = {(win_group != '0) && (cfg.group_second == win_group),
                       (win_group != '0) && (cfg.group_first == win_group)};
  assign flags_kept = state.unlocked & ~group_clr;
  assign egg_bit    = {egg, !egg};

  // State update per request type.
  always_comb begin
    state_next = state;
    case (item.req_type)
      bsd_pkg::REQ_BUTTON: begin
        if (push) begin
          state_next.window = shifted;
          if (matched) begin
            state_next.count       = '0;
            state_next.unlocked    = flags_kept | egg_bit;
            state_next.msg_pending = 1'b1;
            state_next.msg_index   = egg;
          end else if (full) begin
            // No match: the window slides and stays one short of full.
            state_next.count = state.count;
          end else begin
            state_next.count = state.count + 1'b1;
          end
        end
      end
      bsd_pkg::REQ_CLEAR: begin
        state_next.unlocked = state.unlocked & cfg.persistent_mask;
      end
      bsd_pkg::REQ_RESTART: begin
        state_next.count       = '0;
        state_next.msg_pending = 1'b0;
        state_next.msg_index   = 1'b0;
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  // Result fields reflect the state after this item.
  always_comb begin
    result.matched        = matched;
    result.matched_egg    = egg;
    result.newly_unlocked = matched && !(|(flags_kept & egg_bit));
    result.unlocked_mask  = state_next.unlocked;
    result.have_message   = state_next.msg_pending;
    result.message_egg    = state_next.msg_index;
  end

endmodule

`default_nettype wire

### rtl/core/button_sequence_detector.sv
// Top level of the button sequence detector: configuration registers, state
// registers and the result register. Depends on bsd_pkg, bsd_channels and bsd_step.
`default_nettype none
`include "button_sequence_detector_defines.svh"

// Full-press button events fill an eight-entry window of button codes; when the
// window becomes full it is compared with two configured patterns, the first
// enabled one that matches unlocks its egg, and the window empties, otherwise the
// oldest entry drops out. Each accepted item gives exactly one result in the next
// cycle. The block takes one item per cycle: all work for an item is done in a
// single pass of logic from the current state to the result register, and a new
// item is taken whenever that register is empty or its result is being taken in
// the same cycle. Configuration is written through cfg_we, cfg_index and
// cfg_data and must only change while no item is in flight.
module button_sequence_detector (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [bsd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [bsd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  bsd_event_if.sink                                 events,
  bsd_result_if.source                              results
);

  bsd_pkg::cfg_t    cfg;
  bsd_pkg::state_t  state;
  bsd_pkg::state_t  state_next;
  bsd_pkg::item_t   item;
  bsd_pkg::result_t step_result;
  bsd_pkg::result_t res;
  logic             res_valid;
  logic             accept;

  // An item transfers when the result register is free or drains this cycle.
  assign events.ready = !res_valid || results.ready;
  assign accept       = events.valid && events.ready;

  assign item.req_type    = events.req_type;
  assign item.button_code = events.button_code;
  assign item.pressed     = events.pressed;

  bsd_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (step_result)
  );

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buttons_enabled <= 1'b0;
      cfg.pattern_first   <= '0;
      cfg.pattern_second  <= '0;
      cfg.egg_enable      <= '1;
      cfg.group_first     <= '0;
      cfg.group_second    <= '0;
      cfg.persistent_mask <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        bsd_pkg::CFG_BUTTONS_ENABLED: cfg.buttons_enabled <= cfg_data[0];
        bsd_pkg::CFG_PATTERN_FIRST:
          cfg.pattern_first <= cfg_data[bsd_pkg::PATTERN_BITS-1:0];
        bsd_pkg::CFG_PATTERN_SECOND:
          cfg.pattern_second <= cfg_data[bsd_pkg::PATTERN_BITS-1:0];
        bsd_pkg::CFG_EGG_ENABLE:
          cfg.egg_enable <= cfg_data[bsd_pkg::NUM_PATTERNS-1:0];
        bsd_pkg::CFG_GROUP_FIRST:
          cfg.group_first <= cfg_data[bsd_pkg::GROUP_BITS-1:0];
        bsd_pkg::CFG_GROUP_SECOND:
          cfg.group_second <= cfg_data[bsd_pkg::GROUP_BITS-1:0];
        bsd_pkg::CFG_PERSISTENT_MASK:
          cfg.persistent_mask <= cfg_data[bsd_pkg::NUM_PATTERNS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state; the window entries themselves need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      state.window <= state_next.window;
    end
    if (rst) begin
      state.count       <= '0;
      state.unlocked    <= '0;
      state.msg_pending <= 1'b0;
      state.msg_index   <= 1'b0;
    end else if (accept) begin
      state.count       <= state_next.count;
      state.unlocked    <= state_next.unlocked;
      state.msg_pending <= state_next.msg_pending;
      state.msg_index   <= state_next.msg_index;
    end
  end

  // Result register with valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= step_result;
    end
  end

  assign results.valid          = res_valid;
  assign results.matched        = res.matched;
  assign results.matched_egg    = res.matched_egg;
  assign results.newly_unlocked = res.newly_unlocked;
  assign results.unlocked_mask  = res.unlocked_mask;
  assign results.have_message   = res.have_message;
  assign results.message_egg    = res.message_egg;

  // A match always empties the window.
  `BSD_ASSERT(a_match_empties, clk, rst,
    (accept && step_result.matched) |=> (state.count == '0),
    "window not emptied after a match")
  // The fill count never passes the window length.
  `BSD_ASSERT_ALWAYS(a_count_range, clk, rst,
    state.count < bsd_pkg::COUNT_BITS'(bsd_pkg::WINDOW_LEN),
    "window count out of range")
  // A reported match shows its egg unlocked and its message pending.
  `BSD_ASSERT(a_match_result, clk, rst,
    (results.valid && results.matched) |-> (results.unlocked_mask[results.matched_egg] &&
      results.have_message && (results.message_egg == results.matched_egg)),
    "match result inconsistent")
  // Button events leave the window alone while buttons are disabled.
  `BSD_ASSERT(a_disabled_hold, clk, rst,
    (accept && !cfg.buttons_enabled && (events.req_type == bsd_pkg::REQ_BUTTON)) |=>
      (state.count == $past(state.count)),
    "window changed with buttons disabled")

endmodule

`default_nettype wire

### tb/sv/tb_button_sequence_detector.sv
// Self-checking testbench of button_sequence_detector: directed unlock cases, then
// randomized phases of button sequences checked against a behavioral predictor.
// Depends on bsd_pkg, the bsd_channels interfaces and the detector RTL.
module tb_button_sequence_detector;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int GAP_LIMIT     = 18;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 170;
  localparam int PRINT_LIMIT   = 100;
  // Request code with no defined action; the block must leave its state alone.
  localparam logic [bsd_pkg::REQ_BITS-1:0] REQ_RESERVED = 2'd3;

  logic                              clk;
  logic                              rst;
  logic                              cfg_we;
  logic [bsd_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [bsd_pkg::CFG_DATA_BITS-1:0] cfg_data;

  bsd_event_if  ev_ch ();
  bsd_result_if res_ch ();

  // Predictor copy of the configuration and of the detector state.
  bsd_pkg::cfg_t                    cfg_copy;
  logic [bsd_pkg::BUTTON_BITS-1:0]  win_codes [bsd_pkg::WINDOW_LEN];
  int                               win_fill;
  int                               win_head;
  logic [bsd_pkg::NUM_PATTERNS-1:0] unlock_flags;
  logic                             msg_pend;
  logic                             msg_egg;

  bsd_pkg::result_t expected_results [$];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;
  int unsigned      counted_items = 0;
  int               send_gap_max = 0;
  int               take_gap_max = 0;

  button_sequence_detector u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .events    (ev_ch),
    .results   (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL button_sequence_detector");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned seen);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("MISMATCH cycle %0d: %s expected %0h, got %0h", cycle_count, what, want, seen);
  endtask

  // Applies one item to the predictor state and returns the result it causes.
  function automatic bsd_pkg::result_t predict_detector(
      input logic [bsd_pkg::REQ_BITS-1:0] req,
      input logic [bsd_pkg::CODE_BITS-1:0] code,
      input logic press);
    bsd_pkg::result_t                 r;
    int                               slot;
    int                               p;
    int                               q;
    int                               i;
    logic                             hit;
    logic [bsd_pkg::PATTERN_BITS-1:0] word;
    logic [bsd_pkg::GROUP_BITS-1:0]   grp [bsd_pkg::NUM_PATTERNS];
    r = '0;
    grp[0] = cfg_copy.group_first;
    grp[1] = cfg_copy.group_second;
    case (req)
      bsd_pkg::REQ_BUTTON: begin
        if (cfg_copy.buttons_enabled && press && win_fill < bsd_pkg::WINDOW_LEN) begin
          slot = (win_head + win_fill) % bsd_pkg::WINDOW_LEN;
          win_codes[slot] = code[bsd_pkg::BUTTON_BITS-1:0];
          win_fill++;
          if (win_fill == bsd_pkg::WINDOW_LEN) begin
            // Full window: compare oldest first, the lower pattern index wins.
            for (p = 0; p < bsd_pkg::NUM_PATTERNS; p++) begin
              word = (p == 0) ? cfg_copy.pattern_first : cfg_copy.pattern_second;
              hit = cfg_copy.egg_enable[p];
              for (i = 0; i < bsd_pkg::WINDOW_LEN; i++)
                if (win_codes[(win_head + i) % bsd_pkg::WINDOW_LEN] !=
                    word[i*bsd_pkg::BUTTON_BITS +: bsd_pkg::BUTTON_BITS])
                  hit = 1'b0;
              if (hit && !r.matched) begin
                r.matched = 1'b1;
                r.matched_egg = p[0];
              end
            end
            if (r.matched) begin
              // The group clear also hits the winner before its old flag is read.
              if (grp[r.matched_egg] != '0)
                for (q = 0; q < bsd_pkg::NUM_PATTERNS; q++)
                  if (grp[q] == grp[r.matched_egg]) unlock_flags[q] = 1'b0;
              r.newly_unlocked = ~unlock_flags[r.matched_egg];
              unlock_flags[r.matched_egg] = 1'b1;
              msg_pend = 1'b1;
              msg_egg = r.matched_egg;
              win_fill = 0;
            end else begin
              win_head = (win_head + 1) % bsd_pkg::WINDOW_LEN;
              win_fill--;
            end
          end
        end
      end
      bsd_pkg::REQ_CLEAR: unlock_flags &= cfg_copy.persistent_mask;
      bsd_pkg::REQ_RESTART: begin
        win_fill = 0;
        msg_pend = 1'b0;
        msg_egg = 1'b0;
      end
      default: ;
    endcase
    r.unlocked_mask = unlock_flags;
    r.have_message = msg_pend;
    r.message_egg = msg_egg;
    return r;
  endfunction

  // Sends one item after a random gap and records its expected result.
  task automatic send_item(input logic [bsd_pkg::REQ_BITS-1:0] req,
                           input logic [bsd_pkg::CODE_BITS-1:0] code,
                           input logic press);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      ev_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_ch.valid       <= 1'b1;
    ev_ch.req_type    <= req;
    ev_ch.button_code <= code;
    ev_ch.pressed     <= press;
    do @(posedge clk); while (!(ev_ch.valid && ev_ch.ready));
    if (!((req == bsd_pkg::REQ_BUTTON && (!press || !cfg_copy.buttons_enabled)) ||
          req == REQ_RESERVED))
      counted_items++;
    expected_results.push_back(predict_detector(req, code, press));
  endtask

  // Items that leave the window alone.
  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_item(bsd_pkg::REQ_BUTTON, 4'($urandom_range(0, 15)), 1'b0);
      1: send_item(REQ_RESERVED, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      default:
        send_item(bsd_pkg::REQ_CLEAR, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endcase
  endtask

  // Presses the eight codes of a pattern, oldest first, with optional noise between.
  task automatic send_pattern(input logic [bsd_pkg::PATTERN_BITS-1:0] word,
                              input int noise_pct);
    int i;
    for (i = 0; i < bsd_pkg::WINDOW_LEN; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_noise();
      send_item(bsd_pkg::REQ_BUTTON,
                word[i*bsd_pkg::BUTTON_BITS +: bsd_pkg::BUTTON_BITS], 1'b1);
    end
  endtask

  // Stops sending and waits until every expected result has been taken.
  task automatic drain_results();
    ev_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input bsd_pkg::cfg_idx_t idx,
                           input logic [bsd_pkg::CFG_DATA_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      bsd_pkg::CFG_BUTTONS_ENABLED: cfg_copy.buttons_enabled = value[0];
      bsd_pkg::CFG_PATTERN_FIRST:
        cfg_copy.pattern_first = value[bsd_pkg::PATTERN_BITS-1:0];
      bsd_pkg::CFG_PATTERN_SECOND:
        cfg_copy.pattern_second = value[bsd_pkg::PATTERN_BITS-1:0];
      bsd_pkg::CFG_EGG_ENABLE:
        cfg_copy.egg_enable = value[bsd_pkg::NUM_PATTERNS-1:0];
      bsd_pkg::CFG_GROUP_FIRST:
        cfg_copy.group_first = value[bsd_pkg::GROUP_BITS-1:0];
      bsd_pkg::CFG_GROUP_SECOND:
        cfg_copy.group_second = value[bsd_pkg::GROUP_BITS-1:0];
      bsd_pkg::CFG_PERSISTENT_MASK:
        cfg_copy.persistent_mask = value[bsd_pkg::NUM_PATTERNS-1:0];
      default: ;
    endcase
  endtask

  // Writes every register once the block is idle.
  task automatic apply_settings(input logic en,
                                input logic [bsd_pkg::PATTERN_BITS-1:0] pat0,
                                input logic [bsd_pkg::PATTERN_BITS-1:0] pat1,
                                input logic [bsd_pkg::NUM_PATTERNS-1:0] eggs,
                                input logic [bsd_pkg::GROUP_BITS-1:0] grp0,
                                input logic [bsd_pkg::GROUP_BITS-1:0] grp1,
                                input logic [bsd_pkg::NUM_PATTERNS-1:0] keep);
    drain_results();
    write_reg(bsd_pkg::CFG_BUTTONS_ENABLED, 32'(en));
    write_reg(bsd_pkg::CFG_PATTERN_FIRST, pat0);
    write_reg(bsd_pkg::CFG_PATTERN_SECOND, pat1);
    write_reg(bsd_pkg::CFG_EGG_ENABLE, 32'(eggs));
    write_reg(bsd_pkg::CFG_GROUP_FIRST, 32'(grp0));
    write_reg(bsd_pkg::CFG_GROUP_SECOND, 32'(grp1));
    write_reg(bsd_pkg::CFG_PERSISTENT_MASK, 32'(keep));
  endtask

  // Half the time a fully random word, otherwise codes from a small alphabet.
  function automatic logic [bsd_pkg::PATTERN_BITS-1:0] random_pattern();
    logic [bsd_pkg::PATTERN_BITS-1:0] word;
    logic [bsd_pkg::BUTTON_BITS-1:0]  extra;
    int                               i;
    word = $urandom();
    if ($urandom_range(0, 1)) begin
      extra = 4'($urandom_range(0, 15));
      for (i = 0; i < bsd_pkg::WINDOW_LEN; i++)
        case ($urandom_range(0, 2))
          0: word[i*bsd_pkg::BUTTON_BITS +: bsd_pkg::BUTTON_BITS] = '0;
          1: word[i*bsd_pkg::BUTTON_BITS +: bsd_pkg::BUTTON_BITS] = '1;
          default: word[i*bsd_pkg::BUTTON_BITS +: bsd_pkg::BUTTON_BITS] = extra;
        endcase
    end
    return word;
  endfunction

  // Right after reset buttons are off, so presses and unknown requests change nothing.
  task automatic test_reset_state();
    send_gap_max = 0;
    take_gap_max = 0;
    send_item(bsd_pkg::REQ_BUTTON, 4'hF, 1'b1);
    send_item(REQ_RESERVED, 4'h0, 1'b0);
  endtask

  // A half press is dropped, then a full pattern unlocks the first egg.
  task automatic test_first_unlock();
    apply_settings(1'b1, 32'h0F0F_0F0F, 32'h3C3C_C3C3, 2'b11, 4'h0, 4'hF, 2'b10);
    send_gap_max = GAP_LIMIT;
    take_gap_max = GAP_LIMIT;
    send_item(bsd_pkg::REQ_BUTTON, 4'hF, 1'b0);
    send_item(bsd_pkg::REQ_RESTART, 4'h0, 1'b1);
    send_pattern(cfg_copy.pattern_first, 0);
  endtask

  // Equal patterns in one group: the first wins and reclears its own flag; with the
  // first disabled the second wins; a clear with nothing persistent drops both.
  task automatic test_priority_and_groups();
    apply_settings(1'b1, 32'h8421_8421, 32'h8421_8421, 2'b11, 4'h9, 4'h9, 2'b00);
    send_pattern(cfg_copy.pattern_first, 0);
    drain_results();
    write_reg(bsd_pkg::CFG_EGG_ENABLE, 32'd2);
    send_pattern(cfg_copy.pattern_second, 0);
    send_item(bsd_pkg::REQ_CLEAR, 4'h5, 1'b1);
    send_item(bsd_pkg::REQ_RESTART, 4'hA, 1'b0);
  endtask

  // Phases of random settings; most stimulus is pattern sequences with noise.
  task automatic test_random_phases();
    int                               phase;
    int                               target;
    int                               goal;
    int                               pick;
    int                               len;
    int                               i;
    bit                               paused;
    logic [bsd_pkg::PATTERN_BITS-1:0] word;
    logic [bsd_pkg::GROUP_BITS-1:0]   grp0;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      // Register extremes first, then a phase with buttons off, then random settings.
      case (phase)
        0: apply_settings(1'b1, '0, '0, 2'b00, '0, '0, 2'b00);
        1: apply_settings(1'b1, '1, '1, 2'b11, '1, '1, 2'b11);
        2: apply_settings(1'b0, random_pattern(), random_pattern(), 2'b11, 4'h1, 4'h1,
                          2'b01);
        default: begin
          word = random_pattern();
          grp0 = 4'($urandom_range(0, 15));
          apply_settings(1'b1, word, ($urandom_range(0, 3) == 0) ? word : random_pattern(),
                         2'($urandom_range(0, 3)), grp0,
                         $urandom_range(0, 1) ? grp0 : 4'($urandom_range(0, 15)),
                         2'($urandom_range(0, 3)));
        end
      endcase
      if (phase == 3) begin
        send_gap_max = 0;
        take_gap_max = 0;
      end else begin
        send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_LIMIT;
        take_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_LIMIT;
      end
      target = (phase == 2) ? 4 : PHASE_ITEMS;
      goal = counted_items + target;
      paused = 1'b0;
      while (counted_items < goal) begin
        pick = $urandom_range(0, 99);
        word = $urandom_range(0, 1) ? cfg_copy.pattern_second : cfg_copy.pattern_first;
        if (pick < 60) begin
          send_pattern(word, 15);
        end else if (pick < 75) begin
          // Broken sequence: a prefix, then a restart or a stray press.
          len = $urandom_range(1, bsd_pkg::WINDOW_LEN - 1);
          for (i = 0; i < len; i++)
            send_item(bsd_pkg::REQ_BUTTON,
                      word[i*bsd_pkg::BUTTON_BITS +: bsd_pkg::BUTTON_BITS], 1'b1);
          if ($urandom_range(0, 1))
            send_item(bsd_pkg::REQ_RESTART, 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
          else
            send_item(bsd_pkg::REQ_BUTTON, 4'($urandom_range(0, 15)), 1'b1);
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 4))
            send_item(bsd_pkg::REQ_BUTTON, 4'($urandom_range(0, 15)), 1'b1);
        end else if (pick < 95) begin
          send_item(bsd_pkg::REQ_RESTART, 4'($urandom_range(0, 15)),
                    1'($urandom_range(0, 1)));
        end else begin
          send_noise();
        end
        // Once per phase the sender holds off until the result side has caught up.
        if (!paused && counted_items + target / 2 >= goal) begin
          paused = 1'b1;
          drain_results();
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end
  endtask

  // Result side: random stalls, each transfer checked against the oldest expectation.
  initial begin
    bsd_pkg::result_t want;
    bsd_pkg::result_t seen;
    int               stall;
    res_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, take_gap_max);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      seen.matched        = res_ch.matched;
      seen.matched_egg    = res_ch.matched_egg;
      seen.newly_unlocked = res_ch.newly_unlocked;
      seen.unlocked_mask  = res_ch.unlocked_mask;
      seen.have_message   = res_ch.have_message;
      seen.message_egg    = res_ch.message_egg;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 32'(seen));
      end else begin
        want = expected_results.pop_front();
        if (seen.matched !== want.matched)
          report_mismatch("matched", 32'(want.matched), 32'(seen.matched));
        if (seen.matched_egg !== want.matched_egg)
          report_mismatch("matched_egg", 32'(want.matched_egg), 32'(seen.matched_egg));
        if (seen.newly_unlocked !== want.newly_unlocked)
          report_mismatch("newly_unlocked", 32'(want.newly_unlocked),
                          32'(seen.newly_unlocked));
        if (seen.unlocked_mask !== want.unlocked_mask)
          report_mismatch("unlocked_mask", 32'(want.unlocked_mask),
                          32'(seen.unlocked_mask));
        if (seen.have_message !== want.have_message)
          report_mismatch("have_message", 32'(want.have_message), 32'(seen.have_message));
        if (seen.message_egg !== want.message_egg)
          report_mismatch("message_egg", 32'(want.message_egg), 32'(seen.message_egg));
      end
    end
  end

  // Reset, the test sequence, then the verdict.
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    ev_ch.valid = 1'b0;
    ev_ch.req_type = '0;
    ev_ch.button_code = '0;
    ev_ch.pressed = 1'b0;
    cfg_copy = '0;
    cfg_copy.egg_enable = 2'b11;
    cfg_copy.persistent_mask = 2'b11;
    foreach (win_codes[k]) win_codes[k] = '0;
    win_fill = 0;
    win_head = 0;
    unlock_flags = '0;
    msg_pend = 1'b0;
    msg_egg = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_first_unlock();
    test_priority_and_groups();
    test_random_phases();
    drain_results();
    if (mismatch_count == 0)
      $display("PASS button_sequence_detector");
    else
      $display("FAIL button_sequence_detector");
    $finish;
  end

endmodule
